// ===== rtl/e2h_pkg.sv =====
package e2h_pkg;

   // Default build options.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Fixed result format and tolerance register.
   localparam int RES_W   = 48;
   localparam int TOL_W   = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

   // Largest result magnitude and the cap applied to the slope-times-x product.
   localparam logic [RES_W-1:0] RES_MAXMAG = 48'h8000_0000_0000;
   localparam logic [RES_W-1:0] RES_MAX    = 48'h7FFF_FFFF_FFFF;
   localparam logic [RES_W-1:0] RES_MIN    = 48'h8000_0000_0000;
   localparam int PROD_CAP_W = 61;
   localparam logic [PROD_CAP_W-1:0] PROD_CAP = 61'h1000_0000_0000_0000;

   // The multiplier consumes one digit of |x1| per cycle.
   localparam int MUL_DIGIT_W = 16;

   // Edge kinds as reported on the result channel.
   localparam logic [1:0] KIND_VERTICAL   = 2'd0;
   localparam logic [1:0] KIND_HORIZONTAL = 2'd1;
   localparam logic [1:0] KIND_SLOPED     = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic diff;
      logic classify;
      logic div_step;
      logic clamp;
      logic mul_step;
      logic offset;
      logic emit;
   } e2h_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic chain_start;
      logic sloped;
      logic out_free;
   } e2h_sts_type;

endpackage

// ===== rtl/e2h_div.sv =====
module e2h_div
   import e2h_pkg::*;
#(
   parameter int NUM_W = 49,
   parameter int DEN_W = 33
) (
   input  logic             clock,
   input  logic             init,
   input  logic             step,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot
);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   // One restoring step: bring down the next numerator bit and try the divisor.
   always_comb begin
      shifted = {rem_ff, num_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (init) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
      end else if (step) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ===== rtl/e2h_ctrl.sv =====
module e2h_ctrl
   import e2h_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  e2h_sts_type sts,
   output e2h_cmd_type cmd
);

   localparam int DIV_STEPS = COORD_WIDTH + 1 + FRAC_BITS;
   localparam int MUL_STEPS = (COORD_WIDTH + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIFF   = 3'd1;
   localparam logic [2:0] ST_CLASS  = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_CLAMP  = 3'd4;
   localparam logic [2:0] ST_MUL    = 3'd5;
   localparam logic [2:0] ST_OFFSET = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Sequencer: one request at a time, iterating the divider and the multiplier.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = sts.chain_start ? ST_IDLE : ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_CLASS;
         end
         ST_CLASS: begin
            cmd.classify = 1'b1;
            cnt_in       = '0;
            state_in     = sts.sloped ? ST_DIV : ST_EMIT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            cnt_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            cmd.offset = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // The divider never runs past its last quotient bit.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_W'(DIV_STEPS - 1)))
      else $error("divider step count overran");

   // A vertex that only starts a chain produces no work.
   a_chain_start: assert property (@(posedge clock) disable iff (reset)
      (accept && sts.chain_start) |=> (state_ff == ST_IDLE))
      else $error("chain start vertex did not return to idle");

endmodule

// ===== rtl/e2h_datapath.sv =====
module e2h_datapath
   import e2h_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [TOL_W-1:0]       csr_wdata,
   input  logic [COORD_WIDTH-1:0] vertex_x,
   input  logic [COORD_WIDTH-1:0] vertex_y,
   input  logic                   first_vertex,
   input  e2h_cmd_type            cmd,
   output e2h_sts_type            sts,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RES_W-1:0]       normal_x,
   output logic [RES_W-1:0]       normal_y,
   output logic [RES_W-1:0]       offset,
   output logic [1:0]             edge_kind,
   output logic                   saturated
);

   localparam int CW     = COORD_WIDTH;
   localparam int NUM_W  = CW + 1 + FRAC_BITS;
   localparam int QE_W   = (NUM_W > RES_W + 1) ? NUM_W : RES_W + 1;
   localparam int XP     = ((CW + MUL_DIGIT_W - 1) / MUL_DIGIT_W) * MUL_DIGIT_W;
   localparam int PW     = RES_W + XP;
   localparam int SH_W   = PW - FRAC_BITS;
   localparam int SE_W   = (SH_W > PROD_CAP_W) ? SH_W : PROD_CAP_W;
   localparam int BW     = 63;
   localparam logic [RES_W-1:0] UNIT = RES_W'(1) << FRAC_BITS;

   // Tolerance register and chain state.
   logic [TOL_W-1:0]        tol_ff;
   logic signed [CW-1:0]    prev_x_ff, prev_y_ff;
   logic                    have_prev_ff;

   // Working registers for the edge in flight.
   logic signed [CW-1:0]    x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [CW:0]      dx_ff, dy_ff;
   logic                    x_lt_ff, y_dec_ff;
   logic [1:0]              kind_ff;
   logic                    neg_a_ff;
   logic [RES_W-1:0]        a_mag_ff;
   logic                    a_neg_ff;
   logic                    sat_ff;
   logic [XP-1:0]           xm_ff;
   logic [PW-1:0]           acc_ff;
   logic [RES_W-1:0]        b_ff;
   logic                    b_sat_ff;

   // Result register.
   logic                    rsp_valid_ff;
   logic [RES_W-1:0]        nx_ff, ny_ff, off_ff;
   logic [1:0]              kind_out_ff;
   logic                    sat_out_ff;

   // Combinational helpers.
   logic [CW:0]             dx_mag, dy_mag;
   logic                    is_vert, is_horiz;
   logic [NUM_W-1:0]        quot;
   logic [QE_W-1:0]         q_ext;
   logic                    q_big;
   logic [RES_W-1:0]        a_mag_in;
   logic [CW-1:0]           x1_mag;
   logic [MUL_DIGIT_W-1:0]  digit;
   logic [RES_W+MUL_DIGIT_W-1:0] part;
   logic [SH_W-1:0]         sh;
   logic [PROD_CAP_W-1:0]   pm;
   logic [BW-1:0]           y1_w, pm_w, b_full;
   logic                    b_ovf;
   logic [RES_W-1:0]        b_in;
   logic [RES_W-1:0]        a_s;
   logic [RES_W-1:0]        nx_in, ny_in, off_in;
   logic                    sat_in;
   logic                    out_free;

   // Tolerance register write.
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wen) begin
         tol_ff <= csr_wdata;
      end
   end

   // Chain state: every accepted vertex becomes the previous one.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
      end else if (cmd.load) begin
         prev_x_ff    <= vertex_x;
         prev_y_ff    <= vertex_y;
         have_prev_ff <= 1'b1;
      end
   end

   // Edge classification against the tolerance.
   always_comb begin
      dx_mag   = dx_ff[CW] ? (~dx_ff + 1'b1) : dx_ff;
      dy_mag   = dy_ff[CW] ? (~dy_ff + 1'b1) : dy_ff;
      is_vert  = (dx_mag < (CW+1)'(tol_ff)) || (dx_ff == '0);
      is_horiz = (dy_mag < (CW+1)'(tol_ff));
   end

   // Slope magnitude |dy| * 2^FRAC_BITS / |dx|, one quotient bit per cycle.
   e2h_div #(
      .NUM_W (NUM_W),
      .DEN_W (CW + 1)
   ) u_div (
      .clock (clock),
      .init  (cmd.classify),
      .step  (cmd.div_step),
      .num   ({dy_mag, {FRAC_BITS{1'b0}}}),
      .den   (dx_mag),
      .quot  (quot)
   );

   // Slope clamp: a negative slope may reach the most negative value.
   always_comb begin
      q_ext = QE_W'(quot);
      if (neg_a_ff) begin
         q_big = (q_ext > QE_W'(RES_MAXMAG));
      end else begin
         q_big = (q_ext > QE_W'(RES_MAX));
      end
      if (q_big) begin
         a_mag_in = neg_a_ff ? RES_MAXMAG : RES_MAX;
      end else begin
         a_mag_in = q_ext[RES_W-1:0];
      end
      x1_mag = x1_ff[CW-1] ? (~x1_ff + 1'b1) : x1_ff;
   end

   // Product |a| * |x1|, one digit of |x1| per cycle, most significant first.
   always_comb begin
      digit = xm_ff[XP-1 -: MUL_DIGIT_W];
      part  = a_mag_ff * digit;
   end

   // Intercept b = y1 - a*x1 with the product capped and the result clipped.
   always_comb begin
      sh     = acc_ff[PW-1:FRAC_BITS];
      pm     = (SE_W'(sh) > SE_W'(PROD_CAP)) ? PROD_CAP : sh[PROD_CAP_W-1:0];
      y1_w   = BW'(y1_ff);
      pm_w   = BW'(pm);
      b_full = (a_neg_ff ^ x1_ff[CW-1]) ? (y1_w + pm_w) : (y1_w - pm_w);
      b_ovf  = (b_full[BW-1:RES_W-1] != '0) && (b_full[BW-1:RES_W-1] != '1);
      if (b_ovf) begin
         b_in = b_full[BW-1] ? RES_MIN : RES_MAX;
      end else begin
         b_in = b_full[RES_W-1:0];
      end
   end

   // Working registers of the edge computation.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff <= prev_x_ff;
         y1_ff <= prev_y_ff;
         x2_ff <= vertex_x;
         y2_ff <= vertex_y;
      end
      if (cmd.diff) begin
         dx_ff    <= (CW+1)'(x2_ff) - (CW+1)'(x1_ff);
         dy_ff    <= (CW+1)'(y2_ff) - (CW+1)'(y1_ff);
         x_lt_ff  <= (x1_ff < x2_ff);
         y_dec_ff <= (y2_ff < y1_ff);
      end
      if (cmd.classify) begin
         if (is_vert) begin
            kind_ff <= KIND_VERTICAL;
         end else if (is_horiz) begin
            kind_ff <= KIND_HORIZONTAL;
         end else begin
            kind_ff <= KIND_SLOPED;
         end
         neg_a_ff <= dx_ff[CW] ^ dy_ff[CW];
      end
      if (cmd.clamp) begin
         a_mag_ff <= a_mag_in;
         a_neg_ff <= neg_a_ff;
         sat_ff   <= q_big;
         xm_ff    <= XP'(x1_mag);
         acc_ff   <= '0;
      end
      if (cmd.mul_step) begin
         acc_ff <= (acc_ff << MUL_DIGIT_W) + PW'(part);
         xm_ff  <= xm_ff << MUL_DIGIT_W;
      end
      if (cmd.offset) begin
         b_ff     <= b_in;
         b_sat_ff <= b_ovf;
      end
   end

   // Row assembly with the sign convention of each edge kind.
   always_comb begin
      a_s    = a_neg_ff ? (~a_mag_ff + 1'b1) : a_mag_ff;
      nx_in  = '0;
      ny_in  = '0;
      off_in = '0;
      sat_in = 1'b0;
      case (kind_ff)
         KIND_VERTICAL: begin
            nx_in  = y_dec_ff ? UNIT : (~UNIT + 1'b1);
            off_in = y_dec_ff ? RES_W'(x1_ff) : (~RES_W'(x1_ff) + 1'b1);
         end
         KIND_HORIZONTAL: begin
            ny_in  = x_lt_ff ? UNIT : (~UNIT + 1'b1);
            off_in = x_lt_ff ? RES_W'(y1_ff) : (~RES_W'(y1_ff) + 1'b1);
         end
         default: begin
            sat_in = sat_ff | b_sat_ff;
            if (x_lt_ff) begin
               ny_in  = UNIT;
               off_in = b_ff;
               if (a_s == RES_MIN) begin
                  nx_in  = RES_MAX;
                  sat_in = 1'b1;
               end else begin
                  nx_in = ~a_s + 1'b1;
               end
            end else begin
               nx_in = a_s;
               ny_in = ~UNIT + 1'b1;
               if (b_ff == RES_MIN) begin
                  off_in = RES_MAX;
                  sat_in = 1'b1;
               end else begin
                  off_in = ~b_ff + 1'b1;
               end
            end
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Result register: holds until the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         nx_ff       <= nx_in;
         ny_ff       <= ny_in;
         off_ff      <= off_in;
         kind_out_ff <= kind_ff;
         sat_out_ff  <= sat_in;
      end
   end

   // Status back to the controller.
   always_comb begin
      sts.chain_start = first_vertex || !have_prev_ff;
      sts.sloped      = !is_vert && !is_horiz;
      sts.out_free    = out_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign normal_x   = nx_ff;
   assign normal_y   = ny_ff;
   assign offset     = off_ff;
   assign edge_kind  = kind_out_ff;
   assign saturated  = sat_out_ff;

   // A new row is never written over one still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result register overwritten while full");

   // Axis-aligned rows are never clipped.
   a_axis_no_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_out_ff != KIND_SLOPED)) |-> !sat_out_ff)
      else $error("saturation flag on an axis-aligned edge");

endmodule

// ===== rtl/edge_to_halfplane.sv =====
// A request loads the vertex; a sloped edge then runs diff, classify, bit-serial divide
// (COORD_WIDTH+FRAC_BITS+1 quotient bits), clamp, 16-bit-digit multiply and offset; a
// vertical or horizontal edge runs only diff and classify. Emit waits while the output
// is full. A chain-start vertex gives no row; requests are taken one at a time.
// Reset: synchronous, active high; clears the previous vertex, the output valid and sets
// the axis tolerance to 1.
module edge_to_halfplane
   import e2h_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [TOL_W-1:0]       csr_wdata,     // axis_tolerance
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // vertex_x, vertex_y, zero fill to whole bytes
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                   req_tuser,     // first_vertex
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [3*RES_W-1:0]     rsp_tdata,     // normal_x, normal_y, offset
   output logic [2:0]             rsp_tuser      // edge_kind[1:0], saturated
);

   e2h_cmd_type      cmd;
   e2h_sts_type      sts;
   logic [RES_W-1:0] normal_x, normal_y, offset;
   logic [1:0]       edge_kind;
   logic             saturated;

   // Sequencer.
   e2h_ctrl #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Arithmetic and result register.
   e2h_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wen      (csr_wen),
      .csr_wdata    (csr_wdata),
      .vertex_x     (req_tdata[COORD_WIDTH-1:0]),
      .vertex_y     (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .first_vertex (req_tuser),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .normal_x     (normal_x),
      .normal_y     (normal_y),
      .offset       (offset),
      .edge_kind    (edge_kind),
      .saturated    (saturated)
   );

   assign rsp_tdata = {offset, normal_y, normal_x};
   assign rsp_tuser = {saturated, edge_kind};

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import e2h_pkg::*;

   localparam int COORD_W = COORD_WIDTH_DEF;
   localparam int FRAC_W  = FRAC_BITS_DEF;
   // Cycles a sloped edge may still need after its request, with margin.
   localparam int SETTLE_CYCLES = COORD_W + FRAC_W + 12;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int N_DIRECTED    = 26;
   localparam int N_PHASES      = 5;
   localparam int PHASE_VERTICES = 100;
   localparam int IDLE_PCT      = 36;

   localparam longint ROW_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint ROW_MIN = -ROW_MAX - 1;
   localparam longint unsigned MAG_CAP = 64'(RES_MAXMAG);
   localparam longint unsigned MUL_CAP = 64'(PROD_CAP);
   localparam longint UNIT = longint'(1) << FRAC_W;

   typedef enum logic {ROW_VERTEX, ROW_CSR} row_op_type;

   typedef struct packed {
      logic signed [RES_W-1:0] nx;
      logic signed [RES_W-1:0] ny;
      logic signed [RES_W-1:0] off;
      logic [1:0]              kind;
      logic                    sat;
   } halfplane_row_type;

   typedef struct packed {
      row_op_type        op;
      logic [31:0]       x;      // tolerance value on a register row
      logic [31:0]       y;
      logic              start;
      logic              typed;
      halfplane_row_type want;
   } stim_row_type;

   localparam halfplane_row_type NO_ROW = '0;

   // Directed stimulus. Rows with typed set carry a hand-derived expectation;
   // the rest are checked against the predictor.
   localparam stim_row_type STIM [0:N_DIRECTED-1] = '{
      // No previous vertex after reset: starts a chain.
      '{ROW_VERTEX, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1,
        '{48'shFFFF_FFFF_0000, 48'sd0, 48'sd0, KIND_VERTICAL, 1'b0}},
      '{ROW_VERTEX, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1,
        '{48'sd0, 48'sd65536, 48'sd65536, KIND_HORIZONTAL, 1'b0}},
      '{ROW_VERTEX, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1,
        '{48'sd0, 48'shFFFF_FFFF_0000, 48'shFFFF_FFFF_0000, KIND_HORIZONTAL, 1'b0}},
      // Coordinate extremes.
      '{ROW_VERTEX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1,
        '{48'sd65536, 48'shFFFF_FFFF_0000, 48'sd0, KIND_SLOPED, 1'b0}},
      '{ROW_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
        '{48'sd0, 48'sd65536, 48'shFFFF_8000_0000, KIND_HORIZONTAL, 1'b0}},
      '{ROW_VERTEX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1,
        '{48'shFFFF_FFFF_0000, 48'sd0, 48'shFFFF_8000_0001, KIND_VERTICAL, 1'b0}},
      // Vertical edge going down.
      '{ROW_VERTEX, 32'h0003_0000, 32'h0005_0000, 1'b1, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h0003_0000, 32'h0002_0000, 1'b0, 1'b1,
        '{48'sd65536, 48'sd0, 48'sh0000_0003_0000, KIND_VERTICAL, 1'b0}},
      // Steep slopes clip the slope, then the offset.
      '{ROW_VERTEX, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b1,
        '{48'sh8000_0000_0001, 48'sd65536, 48'shFFFF_8000_0000, KIND_SLOPED, 1'b1}},
      '{ROW_VERTEX, 32'h0000_0002, 32'h8000_0000, 1'b0, 1'b1,
        '{48'sh7FFF_FFFF_FFFF, 48'sd65536, 48'sh0000_FFFF_FFFF, KIND_SLOPED, 1'b1}},
      '{ROW_VERTEX, 32'h7FFF_FFFE, 32'h8000_0000, 1'b1, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1,
        '{48'sh8000_0000_0001, 48'sd65536, 48'sh8000_0000_0000, KIND_SLOPED, 1'b1}},
      '{ROW_VERTEX, 32'h7FFF_FFFE, 32'h8000_0000, 1'b0, 1'b1,
        '{48'sh7FFF_FFFF_FFFF, 48'shFFFF_FFFF_0000, 48'sh7FFF_FFFF_FFFF,
          KIND_SLOPED, 1'b1}},
      // Zero tolerance: dx of zero stays vertical, dy of zero becomes sloped.
      '{ROW_CSR, 32'h0000_0000, 32'h0, 1'b0, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h0000_0000, 32'h0000_0005, 1'b0, 1'b1,
        '{48'shFFFF_FFFF_0000, 48'sd0, 48'sd0, KIND_VERTICAL, 1'b0}},
      '{ROW_VERTEX, 32'h0000_0007, 32'h0000_0005, 1'b0, 1'b1,
        '{48'sd0, 48'sd65536, 48'sd5, KIND_SLOPED, 1'b0}},
      '{ROW_VERTEX, 32'h0000_0007, 32'hFFFF_FFFB, 1'b0, 1'b1,
        '{48'sd65536, 48'sd0, 48'sd7, KIND_VERTICAL, 1'b0}},
      // Widest tolerance, just inside and just outside.
      '{ROW_CSR, 32'h0000_FFFF, 32'h0, 1'b0, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h0001_0005, 32'h0010_0000, 1'b0, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h0010_0000, 32'h0010_FFFF, 1'b0, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'hFFF0_0000, 32'h0011_0000, 1'b0, 1'b0, NO_ROW},
      '{ROW_VERTEX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_ROW}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wen = 1'b0;
   logic [TOL_W-1:0]       csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [2*COORD_W-1:0]   req_tdata = '0;      // vertex_x, vertex_y
   logic                   req_tuser = 1'b0;    // first_vertex
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [3*RES_W-1:0]     rsp_tdata;           // normal_x, normal_y, offset
   logic [2:0]             rsp_tuser;           // edge_kind[1:0], saturated

   // Predictor state: previous vertex and the tolerance last written.
   longint                 last_x;
   longint                 last_y;
   bit                     chain_open;
   longint unsigned        tol_shadow;

   halfplane_row_type      pending_rows [$];
   int                     req_idle_pct = IDLE_PCT;
   int                     rsp_idle_pct = IDLE_PCT;
   int                     errors;
   int                     cycles;
   int                     vertices_sent;
   int                     rows_checked;
   int                     n_vertical;
   int                     n_horizontal;
   int                     n_sloped;
   int                     n_clipped;
   int                     tol_settings;

   edge_to_halfplane DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned mag(input longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint clip_row(input longint v, inout bit hit);
      if (v > ROW_MAX) begin
         hit = 1'b1;
         return ROW_MAX;
      end
      if (v < ROW_MIN) begin
         hit = 1'b1;
         return ROW_MIN;
      end
      return v;
   endfunction

   // Advances the previous-vertex state and works out the half-plane row of the
   // closed edge. Returns 0 when the vertex only starts a chain.
   function automatic bit edge_row(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                                   input logic start, output halfplane_row_type row);
      longint          x1, y1, x2, y2, dx, dy, a, p, b, nx, ny, off;
      logic [127:0]    quot, prod;
      longint unsigned pm;
      logic [1:0]      kind;
      bit              sat, neg_a, opens;
      x1 = last_x;
      y1 = last_y;
      x2 = longint'($signed(vx));
      y2 = longint'($signed(vy));
      opens = start || !chain_open;
      last_x = x2;
      last_y = y2;
      chain_open = 1'b1;
      row = '0;
      if (opens) return 1'b0;
      dx = x2 - x1;
      dy = y2 - y1;
      sat = 1'b0;
      if (mag(dx) < tol_shadow || dx == 0) begin
         kind = KIND_VERTICAL;
         ny = 0;
         nx = (y2 < y1) ? UNIT : -UNIT;
         off = (y2 < y1) ? x1 : -x1;
      end else if (mag(dy) < tol_shadow) begin
         kind = KIND_HORIZONTAL;
         nx = 0;
         ny = (x1 < x2) ? UNIT : -UNIT;
         off = (x1 < x2) ? y1 : -y1;
      end else begin
         kind = KIND_SLOPED;
         neg_a = (dy < 0) != (dx < 0);
         quot = (128'(mag(dy)) << FRAC_W) / 128'(mag(dx));
         // The negative slope may reach one step further than the positive one.
         if (neg_a) begin
            if (quot > 128'(MAG_CAP)) begin
               quot = 128'(MAG_CAP);
               sat = 1'b1;
            end
            a = -longint'(quot[63:0]);
         end else begin
            if (quot > 128'(MAG_CAP - 1)) begin
               quot = 128'(MAG_CAP - 1);
               sat = 1'b1;
            end
            a = longint'(quot[63:0]);
         end
         prod = (128'(mag(a)) * 128'(mag(x1))) >> FRAC_W;
         pm = (prod > 128'(MUL_CAP)) ? MUL_CAP : prod[63:0];
         p = ((a < 0) != (x1 < 0)) ? -longint'(pm) : longint'(pm);
         b = clip_row(y1 - p, sat);
         if (x1 < x2) begin
            nx = clip_row(-a, sat);
            ny = UNIT;
            off = b;
         end else begin
            nx = a;
            ny = -UNIT;
            off = clip_row(-b, sat);
         end
      end
      row.nx = nx[RES_W-1:0];
      row.ny = ny[RES_W-1:0];
      row.off = off[RES_W-1:0];
      row.kind = kind;
      row.sat = sat;
      return 1'b1;
   endfunction

   // Picks the next coordinate, biased toward axis-aligned and near-axis edges.
   function automatic logic [31:0] next_coord(input logic [31:0] prev,
                                              input longint unsigned tol);
      int unsigned span;
      span = 32'(tol) + 2;
      case ($urandom_range(9))
         0: return prev;
         1, 2: return prev + 32'($urandom_range(2 * span)) - span;
         3, 4: return $urandom();
         5: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
         default: return prev + 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("[%0t] row %0d %s: got %h, expected %h", $realtime, rows_checked, field,
               got, want);
   endtask

   // Sends one vertex request; the expectation is recorded when it is taken.
   task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                              input logic start, input logic typed,
                              input halfplane_row_type typed_row);
      int                gap;
      halfplane_row_type row;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vy, vx};
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      vertices_sent++;
      if (edge_row(vx, vy, start, row)) begin
         if (typed) row = typed_row;
         pending_rows = {pending_rows, row};
      end
   endtask

   // Writes the tolerance once the block has drained.
   task automatic set_tolerance(input logic [TOL_W-1:0] value);
      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      tol_shadow = value;
      tol_settings++;
   endtask

   // Result side: random back-pressure.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Compare every taken row with the oldest pending expectation.
   always @(posedge clock) begin
      halfplane_row_type got;
      halfplane_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.nx = rsp_tdata[RES_W-1:0];
         got.ny = rsp_tdata[2*RES_W-1:RES_W];
         got.off = rsp_tdata[3*RES_W-1:2*RES_W];
         got.kind = rsp_tuser[1:0];
         got.sat = rsp_tuser[2];
         if (pending_rows.size() == 0) begin
            report_mismatch("row with no edge pending", 64'(got.nx), 64'd0);
         end else begin
            want = pending_rows.pop_front();
            if (got.nx !== want.nx) report_mismatch("normal_x", 64'(got.nx), 64'(want.nx));
            if (got.ny !== want.ny) report_mismatch("normal_y", 64'(got.ny), 64'(want.ny));
            if (got.off !== want.off) report_mismatch("offset", 64'(got.off), 64'(want.off));
            if (got.kind !== want.kind)
               report_mismatch("edge_kind", 64'(got.kind), 64'(want.kind));
            if (got.sat !== want.sat)
               report_mismatch("saturated", 64'(got.sat), 64'(want.sat));
            case (want.kind)
               KIND_VERTICAL:   n_vertical++;
               KIND_HORIZONTAL: n_horizontal++;
               default:         n_sloped++;
            endcase
            if (want.sat) n_clipped++;
         end
         rows_checked++;
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Run limit of %0d cycles reached with %0d rows pending.", CYCLE_LIMIT,
                  pending_rows.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Stimulus: directed rows, then random chains under several tolerances.
   initial begin
      longint unsigned phase_tol [N_PHASES];
      logic [31:0]     cur_x;
      logic [31:0]     cur_y;
      int              sent;
      int              chain_len;
      last_x = 0;
      last_y = 0;
      chain_open = 1'b0;
      tol_shadow = longint'(TOL_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (STIM[i].op == ROW_CSR)
            set_tolerance(STIM[i].x[TOL_W-1:0]);
         else
            send_vertex(STIM[i].x, STIM[i].y, STIM[i].start, STIM[i].typed, STIM[i].want);
      end

      phase_tol[0] = 65535;
      phase_tol[1] = 0;
      phase_tol[2] = $urandom_range(65534, 2);
      phase_tol[3] = 1;
      phase_tol[4] = $urandom_range(255);
      cur_x = 0;
      cur_y = 0;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         set_tolerance(phase_tol[ph][TOL_W-1:0]);
         // One phase runs with both sides at full rate.
         req_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
         rsp_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
         sent = 0;
         while (sent < PHASE_VERTICES) begin
            cur_x = next_coord(cur_x, tol_shadow);
            cur_y = next_coord(cur_y, tol_shadow);
            send_vertex(cur_x, cur_y, 1'b1, 1'b0, NO_ROW);
            sent++;
            chain_len = $urandom_range(10, 1);
            for (int k = 0; k < chain_len; k++) begin
               cur_x = next_coord(cur_x, tol_shadow);
               cur_y = next_coord(cur_y, tol_shadow);
               // An occasional stray chain start breaks the chain.
               send_vertex(cur_x, cur_y, $urandom_range(99) < 4, 1'b0, NO_ROW);
               sent++;
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d vertices under %0d tolerance settings; checked %0d rows.",
               vertices_sent, tol_settings, rows_checked);
      $display("Rows: %0d vertical, %0d horizontal, %0d sloped, %0d clipped.",
               n_vertical, n_horizontal, n_sloped, n_clipped);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
